[hw/rtl/mmss_pkg.sv]
// Package for the MM:SS countdown timer controller.
// Holds the mode and command codes, the timer state record and the digit step helpers.
// No dependencies.
`default_nettype none

package mmss_pkg;

	typedef enum logic [2:0] {
		MODE_STOPPED = 3'd0,
		MODE_RUNNING = 3'd1,
		MODE_SET_SU  = 3'd2,
		MODE_SET_ST  = 3'd3,
		MODE_SET_MU  = 3'd4,
		MODE_SET_MT  = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_ADJUST = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_NONE   = 2'd3
	} command_t;

	localparam logic [3:0] MASK_SU   = 4'h1;
	localparam logic [3:0] MASK_ST   = 4'h2;
	localparam logic [3:0] MASK_MU   = 4'h4;
	localparam logic [3:0] MASK_MT   = 4'h8;
	localparam logic [3:0] MASK_NONE = 4'h0;

	// Largest value of a units digit (modulo 10) and of a tens digit (modulo 6).
	localparam logic [3:0] UNITS_TOP = 4'd9;
	localparam logic [2:0] TENS_TOP  = 3'd5;

	typedef struct packed {
		mode_t      mode;
		logic       start_last;
		logic       set_last;
		logic [3:0] sec_units;
		logic [2:0] sec_tens;
		logic [3:0] min_units;
		logic [2:0] min_tens;
	} timer_state_t;

	localparam timer_state_t STATE_RESET = '{
		mode:       MODE_STOPPED,
		start_last: 1'b0,
		set_last:   1'b0,
		sec_units:  UNITS_TOP,
		sec_tens:   TENS_TOP,
		min_units:  UNITS_TOP,
		min_tens:   TENS_TOP
	};

	function automatic logic [3:0] digit_inc(logic [3:0] d, logic [3:0] top);
		return (d < top) ? 4'(d + 4'd1) : 4'd0;
	endfunction

	function automatic logic [3:0] digit_dec(logic [3:0] d, logic [3:0] top);
		return (d != 4'd0) ? 4'(d - 4'd1) : top;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/mmss_if.sv]
// Valid/ready channel interfaces for the MM:SS countdown timer controller.
// Event channel and result channel; no dependencies.
`default_nettype none

interface mmss_event_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic       up_button;
	logic       down_button;
	logic       set_button;
	logic       start_button;

	modport source (output valid, command, up_button, down_button, set_button, start_button,
		input ready);
	modport sink (input valid, command, up_button, down_button, set_button, start_button,
		output ready);
endinterface

interface mmss_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [3:0] digit_select_mask;
	logic [2:0] minutes_tens;
	logic [3:0] minutes_units;
	logic [2:0] seconds_tens;
	logic [3:0] seconds_units;
	logic       at_zero;

	modport source (output valid, mode, digit_select_mask, minutes_tens, minutes_units,
		seconds_tens, seconds_units, at_zero, input ready);
	modport sink (input valid, mode, digit_select_mask, minutes_tens, minutes_units,
		seconds_tens, seconds_units, at_zero, output ready);
endinterface

`default_nettype wire

[hw/rtl/mmss_step_logic.sv]
// Next-state logic of the MM:SS countdown timer: mode machine, digit adjust and countdown.
// Depends on mmss_pkg.
`default_nettype none

module mmss_step_logic (
	input  mmss_pkg::timer_state_t cur,
	input  logic [1:0]             command,
	input  logic                   up_button,
	input  logic                   down_button,
	input  logic                   set_button,
	input  logic                   start_button,
	output mmss_pkg::timer_state_t nxt,
	output logic [3:0]             mask
);

	logic zero;
	logic start_rise;
	logic set_rise;
	logic [3:0] st_wide;
	logic [3:0] mt_wide;
	logic [3:0] adj_sel;
	logic [3:0] adj_top;
	logic [3:0] adj_val;
	logic borrow_su;
	logic borrow_st;
	logic borrow_mu;

	assign zero = (cur.sec_units == 4'd0) && (cur.sec_tens == 3'd0) &&
		(cur.min_units == 4'd0) && (cur.min_tens == 3'd0);
	assign start_rise = !cur.start_last && start_button;
	assign set_rise   = !cur.set_last && set_button;
	assign st_wide    = {1'b0, cur.sec_tens};
	assign mt_wide    = {1'b0, cur.min_tens};

	always_comb begin
		unique case (cur.mode)
			mmss_pkg::MODE_SET_SU: mask = mmss_pkg::MASK_SU;
			mmss_pkg::MODE_SET_ST: mask = mmss_pkg::MASK_ST;
			mmss_pkg::MODE_SET_MU: mask = mmss_pkg::MASK_MU;
			mmss_pkg::MODE_SET_MT: mask = mmss_pkg::MASK_MT;
			default:               mask = mmss_pkg::MASK_NONE;
		endcase
	end

	// The digit under adjustment and its wrap value.
	always_comb begin
		unique case (cur.mode)
			mmss_pkg::MODE_SET_ST: begin
				adj_sel = st_wide;
				adj_top = {1'b0, mmss_pkg::TENS_TOP};
			end
			mmss_pkg::MODE_SET_MU: begin
				adj_sel = cur.min_units;
				adj_top = mmss_pkg::UNITS_TOP;
			end
			mmss_pkg::MODE_SET_MT: begin
				adj_sel = mt_wide;
				adj_top = {1'b0, mmss_pkg::TENS_TOP};
			end
			default: begin
				adj_sel = cur.sec_units;
				adj_top = mmss_pkg::UNITS_TOP;
			end
		endcase
		if (up_button) begin
			adj_val = mmss_pkg::digit_inc(adj_sel, adj_top);
		end else if (down_button) begin
			adj_val = mmss_pkg::digit_dec(adj_sel, adj_top);
		end else begin
			adj_val = adj_sel;
		end
	end

	assign borrow_su = (cur.sec_units == 4'd0);
	assign borrow_st = borrow_su && (cur.sec_tens == 3'd0);
	assign borrow_mu = borrow_st && (cur.min_units == 4'd0);

	always_comb begin
		nxt = cur;
		unique case (command)
			mmss_pkg::CMD_SAMPLE: begin
				unique case (cur.mode)
					mmss_pkg::MODE_STOPPED: begin
						nxt.start_last = start_button;
						if (start_rise && !zero) begin
							nxt.mode = mmss_pkg::MODE_RUNNING;
						end else begin
							// Set is only looked at when start did not launch the timer.
							nxt.set_last = set_button;
							if (set_rise) begin
								nxt.mode = mmss_pkg::MODE_SET_SU;
							end
						end
					end
					mmss_pkg::MODE_RUNNING: begin
						nxt.start_last = start_button;
						if (start_rise || zero) begin
							nxt.mode = mmss_pkg::MODE_STOPPED;
						end
					end
					mmss_pkg::MODE_SET_SU: begin
						nxt.set_last = set_button;
						if (set_rise) nxt.mode = mmss_pkg::MODE_SET_ST;
					end
					mmss_pkg::MODE_SET_ST: begin
						nxt.set_last = set_button;
						if (set_rise) nxt.mode = mmss_pkg::MODE_SET_MU;
					end
					mmss_pkg::MODE_SET_MU: begin
						nxt.set_last = set_button;
						if (set_rise) nxt.mode = mmss_pkg::MODE_SET_MT;
					end
					mmss_pkg::MODE_SET_MT: begin
						nxt.set_last = set_button;
						if (set_rise) nxt.mode = mmss_pkg::MODE_STOPPED;
					end
					default: nxt.mode = mmss_pkg::MODE_STOPPED;
				endcase
			end
			mmss_pkg::CMD_ADJUST: begin
				unique case (cur.mode)
					mmss_pkg::MODE_SET_SU: nxt.sec_units = adj_val;
					mmss_pkg::MODE_SET_ST: nxt.sec_tens  = adj_val[2:0];
					mmss_pkg::MODE_SET_MU: nxt.min_units = adj_val;
					mmss_pkg::MODE_SET_MT: nxt.min_tens  = adj_val[2:0];
					default: ;
				endcase
			end
			mmss_pkg::CMD_TICK: begin
				if (cur.mode == mmss_pkg::MODE_RUNNING) begin
					// Countdown with borrow; 00:00 wraps to 59:59.
					nxt.sec_units = mmss_pkg::digit_dec(cur.sec_units, mmss_pkg::UNITS_TOP);
					if (borrow_su) begin
						nxt.sec_tens = 3'(mmss_pkg::digit_dec(st_wide,
							{1'b0, mmss_pkg::TENS_TOP}));
					end
					if (borrow_st) begin
						nxt.min_units = mmss_pkg::digit_dec(cur.min_units,
							mmss_pkg::UNITS_TOP);
					end
					if (borrow_mu) begin
						nxt.min_tens = 3'(mmss_pkg::digit_dec(mt_wide,
							{1'b0, mmss_pkg::TENS_TOP}));
					end
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/mmss_countdown_timer_controller_core.sv]
// Top level of the MM:SS countdown timer controller.
// Depends on mmss_pkg, mmss_if (mmss_event_if, mmss_result_if) and mmss_step_logic.
//
// Usage:
//   events  : one transfer per command (button sample, digit adjust or one-second tick)
//             with the current button levels.
//   results : one transfer per event with the mode, the one-hot digit being set (taken
//             from the mode before the event), the four BCD digits and the zero flag.
//   The event register loads at the edge of the event transfer, and the next-state logic
//   feeds the result register, which loads once it is empty or being drained; the result
//   then stays valid until it is taken.
//   Throughput is one event per cycle while the receiver takes each result; the timer
//   registers take their next state from combinational next-state logic.
//   When the receiver stalls, the result register holds, the event register fills, and
//   events.ready drops until the result is taken; nothing is dropped.
//   Reset sets the timer to 59:59, stopped, with both remembered button levels low, and
//   empties both registers.
`default_nettype none

module mmss_countdown_timer_controller_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	mmss_event_if.sink         events,
	mmss_result_if.source      results
);

	logic       valid_s1;
	logic [1:0] command_s1;
	logic       up_s1;
	logic       down_s1;
	logic       set_s1;
	logic       start_s1;

	mmss_pkg::timer_state_t state_q;
	mmss_pkg::timer_state_t state_nxt;
	logic [3:0]             mask_nxt;

	logic       out_valid_q;
	logic [2:0] mode_q;
	logic [3:0] mask_q;
	logic [2:0] min_tens_q;
	logic [3:0] min_units_q;
	logic [2:0] sec_tens_q;
	logic [3:0] sec_units_q;
	logic       at_zero_q;

	logic advance;
	logic at_zero_nxt;

	// The event in stage 1 moves on when the result register is empty or being drained.
	assign advance      = valid_s1 && (!out_valid_q || results.ready);
	assign events.ready = !valid_s1 || advance;

	mmss_step_logic u_step (
		.cur          (state_q),
		.command      (command_s1),
		.up_button    (up_s1),
		.down_button  (down_s1),
		.set_button   (set_s1),
		.start_button (start_s1),
		.nxt          (state_nxt),
		.mask         (mask_nxt)
	);

	assign at_zero_nxt = (state_nxt.sec_units == 4'd0) && (state_nxt.sec_tens == 3'd0) &&
		(state_nxt.min_units == 4'd0) && (state_nxt.min_tens == 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= mmss_pkg::STATE_RESET;
		end else begin
			if (events.ready) begin
				valid_s1 <= events.valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (events.ready && events.valid) begin
			command_s1 <= events.command;
			up_s1      <= events.up_button;
			down_s1    <= events.down_button;
			set_s1     <= events.set_button;
			start_s1   <= events.start_button;
		end
		if (advance) begin
			mode_q      <= 3'(state_nxt.mode);
			mask_q      <= mask_nxt;
			min_tens_q  <= state_nxt.min_tens;
			min_units_q <= state_nxt.min_units;
			sec_tens_q  <= state_nxt.sec_tens;
			sec_units_q <= state_nxt.sec_units;
			at_zero_q   <= at_zero_nxt;
		end
	end

	assign results.valid             = out_valid_q;
	assign results.mode              = mode_q;
	assign results.digit_select_mask = mask_q;
	assign results.minutes_tens      = min_tens_q;
	assign results.minutes_units     = min_units_q;
	assign results.seconds_tens      = sec_tens_q;
	assign results.seconds_units     = sec_units_q;
	assign results.at_zero           = at_zero_q;

endmodule

`default_nettype wire

[tb/countdown_tb_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the MM:SS countdown timer testbench: the expected timer state and the queue
// of expected readouts. Depends on mmss_pkg for the mode and command codes.
package countdown_tb_pkg;
	import mmss_pkg::*;

	typedef struct packed {
		logic [2:0] mode;
		logic [3:0] mask;
		logic [2:0] min_tens;
		logic [3:0] min_units;
		logic [2:0] sec_tens;
		logic [3:0] sec_units;
		logic       at_zero;
	} timer_readout_t;

	class countdown_scoreboard;
		mode_t          mode_now;
		bit             start_prev;
		bit             set_prev;
		logic [3:0]     sec_units;
		logic [2:0]     sec_tens;
		logic [3:0]     min_units;
		logic [2:0]     min_tens;
		timer_readout_t expected_readouts[$];
		int unsigned    checked;
		int unsigned    mismatches;
		int unsigned    zero_readouts;

		function new();
			mode_now   = MODE_STOPPED;
			start_prev = 1'b0;
			set_prev   = 1'b0;
			sec_units  = UNITS_TOP;
			sec_tens   = TENS_TOP;
			min_units  = UNITS_TOP;
			min_tens   = TENS_TOP;
		endfunction

		function bit timer_at_zero();
			return sec_units == 4'd0 && sec_tens == 3'd0 && min_units == 4'd0 && min_tens == 3'd0;
		endfunction

		static function logic [3:0] wrap_step(logic [3:0] d, bit up, logic [3:0] top);
			if (up) begin
				return (d < top) ? d + 4'd1 : 4'd0;
			end
			return (d != 4'd0) ? d - 4'd1 : top;
		endfunction

		// Each remembered level follows its button only when the mode tests that button.
		function void step_buttons(bit set_now, bit start_now);
			bit zero;
			bit start_rose;
			bit set_rose;
			zero = timer_at_zero();
			case (mode_now)
				MODE_STOPPED: begin
					start_rose = !start_prev && start_now;
					start_prev = start_now;
					if (start_rose && !zero) begin
						mode_now = MODE_RUNNING;
					end else begin
						set_rose = !set_prev && set_now;
						set_prev = set_now;
						if (set_rose) mode_now = MODE_SET_SU;
					end
				end
				MODE_RUNNING: begin
					start_rose = !start_prev && start_now;
					start_prev = start_now;
					if (start_rose || zero) mode_now = MODE_STOPPED;
				end
				MODE_SET_SU, MODE_SET_ST, MODE_SET_MU: begin
					set_rose = !set_prev && set_now;
					set_prev = set_now;
					if (set_rose) mode_now = mode_t'(mode_now + 3'd1);
				end
				MODE_SET_MT: begin
					set_rose = !set_prev && set_now;
					set_prev = set_now;
					if (set_rose) mode_now = MODE_STOPPED;
				end
				default: mode_now = MODE_STOPPED;
			endcase
		endfunction

		function void adjust_digit(bit up, bit down);
			if (!up && !down) return;
			case (mode_now)
				MODE_SET_SU: sec_units = wrap_step(sec_units, up, UNITS_TOP);
				MODE_SET_ST: sec_tens = 3'(wrap_step({1'b0, sec_tens}, up, {1'b0, TENS_TOP}));
				MODE_SET_MU: min_units = wrap_step(min_units, up, UNITS_TOP);
				MODE_SET_MT: min_tens = 3'(wrap_step({1'b0, min_tens}, up, {1'b0, TENS_TOP}));
				default: ;
			endcase
		endfunction

		// Count down one second with borrow; 00:00 rolls over to 59:59.
		function void count_second();
			if (mode_now != MODE_RUNNING) return;
			if (sec_units != 4'd0) begin
				sec_units = sec_units - 4'd1;
			end else begin
				sec_units = UNITS_TOP;
				if (sec_tens != 3'd0) begin
					sec_tens = sec_tens - 3'd1;
				end else begin
					sec_tens = TENS_TOP;
					if (min_units != 4'd0) begin
						min_units = min_units - 4'd1;
					end else begin
						min_units = UNITS_TOP;
						min_tens = (min_tens != 3'd0) ? min_tens - 3'd1 : TENS_TOP;
					end
				end
			end
		endfunction

		function void note_event(command_t cmd, bit up, bit down, bit set_now, bit start_now);
			timer_readout_t r;
			case (mode_now)
				MODE_SET_SU: r.mask = MASK_SU;
				MODE_SET_ST: r.mask = MASK_ST;
				MODE_SET_MU: r.mask = MASK_MU;
				MODE_SET_MT: r.mask = MASK_MT;
				default:     r.mask = MASK_NONE;
			endcase
			case (cmd)
				CMD_SAMPLE: step_buttons(set_now, start_now);
				CMD_ADJUST: adjust_digit(up, down);
				CMD_TICK:   count_second();
				default: ;
			endcase
			r.mode      = mode_now;
			r.min_tens  = min_tens;
			r.min_units = min_units;
			r.sec_tens  = sec_tens;
			r.sec_units = sec_units;
			r.at_zero   = timer_at_zero();
			if (r.at_zero) zero_readouts++;
			expected_readouts.push_back(r);
		endfunction

		function void check_readout(timer_readout_t got);
			timer_readout_t want;
			if (expected_readouts.size() == 0) begin
				if (mismatches < 10) begin
					$display("result transfer with nothing expected: mode %0d mask %h %0d%0d:%0d%0d",
						got.mode, got.mask, got.min_tens, got.min_units, got.sec_tens,
						got.sec_units);
				end
				mismatches++;
				return;
			end
			want = expected_readouts.pop_front();
			checked++;
			if (got.mode !== want.mode || got.mask !== want.mask ||
					got.min_tens !== want.min_tens || got.min_units !== want.min_units ||
					got.sec_tens !== want.sec_tens || got.sec_units !== want.sec_units ||
					got.at_zero !== want.at_zero) begin
				if (mismatches < 10) begin
					$display("result %0d wrong (expected/actual): mode %0d/%0d mask %h/%h",
						checked, want.mode, got.mode, want.mask, got.mask);
					$display("  time %0d%0d:%0d%0d/%0d%0d:%0d%0d zero %0b/%0b",
						want.min_tens, want.min_units, want.sec_tens, want.sec_units,
						got.min_tens, got.min_units, got.sec_tens, got.sec_units,
						want.at_zero, got.at_zero);
				end
				mismatches++;
			end
		endfunction
	endclass
endpackage

[tb/tb_mmss_countdown_timer_controller_core.sv]
`timescale 1ns / 1ps
// Testbench top for mmss_countdown_timer_controller_core: directed and random command
// streams with random stalls on both channels. Depends on mmss_pkg, mmss_if, countdown_tb_pkg.
module tb_mmss_countdown_timer_controller_core;
	import mmss_pkg::*;
	import countdown_tb_pkg::*;

	localparam int unsigned STALL_LIMIT  = 1000;
	localparam int unsigned TARGET_ITEMS = 1550;

	logic clk;
	logic arst_n;

	mmss_event_if  ev();
	mmss_result_if res();

	mmss_countdown_timer_controller_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.events(ev),
		.results(res)
	);

	countdown_scoreboard timer_sb;
	int unsigned         stalled_cycles = 0;
	int unsigned         counted_events = 0;
	int unsigned         per_command[4];
	bit                  sender_bursting = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit coin();
		return bit'($urandom_range(0, 1));
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (sender_bursting) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [3:0] digit_in_setting(int unsigned idx);
		case (idx)
			0:       return timer_sb.sec_units;
			1:       return {1'b0, timer_sb.sec_tens};
			2:       return timer_sb.min_units;
			default: return {1'b0, timer_sb.min_tens};
		endcase
	endfunction

	// One event transfer; the expectation is noted at the edge that accepts it.
	task automatic send_event(command_t cmd, bit up, bit down, bit set_now, bit start_now);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			ev.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ev.valid        <= 1'b1;
		ev.command      <= cmd;
		ev.up_button    <= up;
		ev.down_button  <= down;
		ev.set_button   <= set_now;
		ev.start_button <= start_now;
		do @(posedge clk); while (!ev.ready);
		timer_sb.note_event(cmd, up, down, set_now, start_now);
		per_command[cmd]++;
		if (cmd != CMD_NONE) counted_events++;
	endtask

	task automatic sample_levels(bit set_now, bit start_now);
		send_event(CMD_SAMPLE, coin(), coin(), set_now, start_now);
	endtask

	task automatic set_rise();
		sample_levels(1'b0, 1'b0);
		sample_levels(1'b1, 1'b0);
	endtask

	task automatic start_rise();
		sample_levels(1'b0, 1'b0);
		sample_levels(1'b0, 1'b1);
	endtask

	task automatic drain_results();
		ev.valid <= 1'b0;
		do @(posedge clk); while (timer_sb.expected_readouts.size() != 0);
	endtask

	task automatic random_noise(int unsigned count);
		repeat (count) send_event(command_t'($urandom_range(0, 3)), coin(), coin(), coin(), coin());
	endtask

	// Walk through the four setting modes and dial each digit toward a goal, mostly short
	// times so that the countdown reaches zero.
	task automatic program_time();
		logic [3:0]  goal[4];
		int unsigned roll;
		int unsigned presses;
		bit          go_up;
		while (timer_sb.mode_now != MODE_STOPPED) begin
			if (timer_sb.mode_now == MODE_RUNNING) start_rise();
			else set_rise();
		end
		set_rise();
		roll = $urandom_range(0, 9);
		if (roll < 7) begin
			goal[0] = 4'($urandom_range(0, 9));
			goal[1] = 4'($urandom_range(0, 5));
			goal[2] = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 1)) : 4'd0;
			goal[3] = 4'd0;
		end else if (roll == 7) begin
			goal = '{4'd0, 4'd0, 4'd0, 4'd0};
		end else begin
			goal[0] = 4'($urandom_range(0, 9));
			goal[1] = 4'($urandom_range(0, 5));
			goal[2] = 4'($urandom_range(0, 9));
			goal[3] = 4'($urandom_range(0, 5));
		end
		for (int unsigned i = 0; i < 4; i++) begin
			go_up = coin();
			presses = 0;
			while (digit_in_setting(i) != goal[i] && presses < 12) begin
				if ($urandom_range(0, 7) == 0) begin
					if (coin()) sample_levels(1'b0, coin());
					else send_event(command_t'($urandom_range(2, 3)), coin(), coin(), coin(), coin());
				end
				send_event(CMD_ADJUST, go_up, go_up ? coin() : 1'b1, coin(), coin());
				presses++;
			end
			set_rise();
		end
	endtask

	// Start the timer and tick it down past zero now and then, so that it rolls over.
	task automatic run_down();
		int unsigned total;
		int unsigned ticks;
		total = timer_sb.min_tens * 600 + timer_sb.min_units * 60 + timer_sb.sec_tens * 10
			+ timer_sb.sec_units;
		start_rise();
		ticks = (total <= 120) ? total + $urandom_range(0, 3) : $urandom_range(5, 60);
		repeat (ticks) begin
			if ($urandom_range(0, 9) == 0) begin
				if (coin()) sample_levels(coin(), 1'b1);
				else send_event(CMD_ADJUST, coin(), coin(), coin(), coin());
			end
			send_event(CMD_TICK, coin(), coin(), coin(), coin());
		end
		if (coin()) start_rise();
	endtask

	// Result side: check every transfer and stall at random, with long ready stretches.
	initial begin
		timer_readout_t seen;
		int unsigned    hold_left;
		int unsigned    roll;
		bit             ready_next;
		res.ready = 1'b0;
		hold_left = 0;
		ready_next = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res.valid && res.ready) begin
				seen.mode      = res.mode;
				seen.mask      = res.digit_select_mask;
				seen.min_tens  = res.minutes_tens;
				seen.min_units = res.minutes_units;
				seen.sec_tens  = res.seconds_tens;
				seen.sec_units = res.seconds_units;
				seen.at_zero   = res.at_zero;
				timer_sb.check_readout(seen);
			end
			if ((ev.valid && ev.ready) || (res.valid && res.ready)) stalled_cycles = 0;
			else stalled_cycles++;
			if (hold_left == 0) begin
				roll = $urandom_range(0, 99);
				if (roll < 10) begin
					ready_next = 1'b1;
					hold_left = $urandom_range(40, 150);
				end else if (roll < 65) begin
					ready_next = 1'b1;
					hold_left = $urandom_range(1, 4);
				end else if (roll < 95) begin
					ready_next = 1'b0;
					hold_left = $urandom_range(1, 3);
				end else begin
					ready_next = 1'b0;
					hold_left = $urandom_range(10, 30);
				end
			end
			hold_left--;
			res.ready <= ready_next;
		end
	end

	initial begin
		@(posedge arst_n);
		while (stalled_cycles < STALL_LIMIT) @(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int unsigned roll;
		timer_sb = new();
		arst_n = 1'b0;
		ev.valid = 1'b0;
		ev.command = CMD_NONE;
		ev.up_button = 1'b0;
		ev.down_button = 1'b0;
		ev.set_button = 1'b0;
		ev.start_button = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: digit wraps both ways, up over down, start refused at zero with a set
		// edge taken in its place, and a running timer halted by reaching zero.
		send_event(CMD_NONE, 1'b1, 1'b1, 1'b1, 1'b1);
		send_event(CMD_SAMPLE, 1'b0, 1'b0, 1'b1, 1'b0);
		send_event(CMD_ADJUST, 1'b1, 1'b1, 1'b0, 1'b0);
		send_event(CMD_ADJUST, 1'b0, 1'b1, 1'b0, 1'b0);
		send_event(CMD_ADJUST, 1'b1, 1'b0, 1'b0, 1'b0);
		send_event(CMD_ADJUST, 1'b1, 1'b0, 1'b0, 1'b0);
		set_rise();
		send_event(CMD_ADJUST, 1'b1, 1'b0, 1'b0, 1'b0);
		set_rise();
		send_event(CMD_ADJUST, 1'b1, 1'b0, 1'b0, 1'b0);
		set_rise();
		send_event(CMD_ADJUST, 1'b1, 1'b0, 1'b0, 1'b0);
		send_event(CMD_ADJUST, 1'b0, 1'b1, 1'b0, 1'b0);
		send_event(CMD_ADJUST, 1'b1, 1'b0, 1'b0, 1'b0);
		set_rise();
		send_event(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0);
		send_event(CMD_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b1);
		send_event(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0);
		send_event(CMD_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b1);
		send_event(CMD_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b0);
		send_event(CMD_SAMPLE, 1'b0, 1'b0, 1'b1, 1'b1);
		drain_results();

		while (counted_events < TARGET_ITEMS) begin
			sender_bursting = ($urandom_range(0, 5) == 0);
			roll = $urandom_range(0, 19);
			if (roll < 14) begin
				program_time();
				run_down();
			end else if (roll < 19) begin
				random_noise($urandom_range(4, 16));
			end else begin
				drain_results();
			end
		end

		ev.valid <= 1'b0;
		while (timer_sb.expected_readouts.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d result transfers checked: %0d button samples, %0d adjusts, %0d ticks, %0d unused",
			timer_sb.checked, per_command[CMD_SAMPLE], per_command[CMD_ADJUST],
			per_command[CMD_TICK], per_command[CMD_NONE]);
		$display("timer read 00:00 in %0d results; %0d mismatches",
			timer_sb.zero_readouts, timer_sb.mismatches);
		if (timer_sb.mismatches == 0 && timer_sb.expected_readouts.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

[sim.f]
hw/rtl/mmss_pkg.sv
hw/rtl/mmss_if.sv
hw/rtl/mmss_step_logic.sv
hw/rtl/mmss_countdown_timer_controller_core.sv
tb/countdown_tb_pkg.sv
tb/tb_mmss_countdown_timer_controller_core.sv
